// ===== rtl/core/fenwick_tree_prefix_sum_core_assert.svh =====
// Assertion macros shared by the Fenwick tree prefix-sum core.
`ifndef FENWICK_TREE_PREFIX_SUM_CORE_ASSERT_SVH
`define FENWICK_TREE_PREFIX_SUM_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checks a property at every rising edge of clk outside reset.
`define FWT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("fenwick core assertion failed");

// Checks that a condition in one cycle leads to another in the next cycle.
`define FWT_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("fenwick core sequencing assertion failed");

`else

`define FWT_ASSERT(lbl, prop)
`define FWT_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

// ===== rtl/core/fwt_pkg.sv =====
// Types and fixed constants of the Fenwick tree prefix-sum core.
`timescale 1ns / 1ps
`default_nettype none

package fwt_pkg;

	localparam int SUM_W      = 64;
	localparam int DELTA_W    = 32;
	localparam int INDEX_W    = 11;
	localparam int SIZE_REG_W = 11;

	localparam logic [SIZE_REG_W-1:0] SIZE_RESET = 11'd1024;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef logic [SUM_W-1:0] sum_t;

endpackage

`default_nettype wire

// ===== rtl/core/fwt_ram.sv =====
// Partial-sum memory: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module fwt_ram #(
	parameter int DEPTH = 1025,
	parameter int AW    = 11
) (
	input  wire              clk,
	input  wire              we,
	input  wire [AW-1:0]     waddr,
	input  wire fwt_pkg::sum_t wdata,
	input  wire              re,
	input  wire [AW-1:0]     raddr,
	output fwt_pkg::sum_t    rdata
);
	import fwt_pkg::*;

	sum_t mem [0:DEPTH-1];
	sum_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/fenwick_tree_prefix_sum_core.sv =====
// Top level of the Fenwick tree prefix-sum core: sequencer around the partial-sum memory.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake                Payload
// in       input      in_valid / in_ready      operation, index, delta
// out      output     out_valid / out_ready    prefix_sum
// cfg      input      cfg_valid / cfg_ready    size_in_use
//
// An add request walks up the tree and a query walks down it; each visits k
// tree entries, with k at most log2(SIZE)+1, reading one entry per cycle
// through the single read port of the partial-sum memory.
// An add at index zero or above the size in use is dropped without a walk.
// After reset a clearing pass zeroes all SIZE+1 memory entries; no input
// request is taken during it, while configuration writes are always taken.
// A finished query result waits in the output register while the next
// request is accepted; a later query holds only if that register is still full.

module fenwick_tree_prefix_sum_core #(
	parameter int SIZE = 1024
) (
	input  wire                                  clk,
	input  wire                                  arst_n,

	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire                                  operation,
	input  wire [fwt_pkg::INDEX_W-1:0]           index,
	input  wire signed [fwt_pkg::DELTA_W-1:0]    delta,

	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic signed [fwt_pkg::SUM_W-1:0]     prefix_sum,

	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire [fwt_pkg::SIZE_REG_W-1:0]        size_in_use
);
	import fwt_pkg::*;

	// Memory address covers positions 0..SIZE; walk positions reach 2*SIZE.
	localparam int AW = $clog2(SIZE + 1);
	localparam int PW = $clog2(2 * SIZE + 1);
	localparam int CW = (PW > SIZE_REG_W) ? PW : SIZE_REG_W;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_UPD   = 3'd2;
	localparam logic [2:0] ST_QRY   = 3'd3;
	localparam logic [2:0] ST_QOUT  = 3'd4;

	logic [2:0]            state_q;
	logic [AW-1:0]         clr_q;
	logic [SIZE_REG_W-1:0] size_q;
	logic                  out_valid_q;

	logic [PW-1:0]         pos_q;
	logic [PW-1:0]         lim_q;
	sum_t                  delta_q;
	sum_t                  acc_q;
	sum_t                  prefix_sum_q;

	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	sum_t                  mem_wdata;
	logic                  mem_re;
	logic [AW-1:0]         mem_raddr;
	sum_t                  mem_rdata;

	logic [CW-1:0]         size_c;
	logic [CW-1:0]         eff_c;
	logic [CW-1:0]         idx_c;
	logic [CW-1:0]         qpos_c;
	logic [PW-1:0]         eff;
	logic [PW-1:0]         upd_start;
	logic [PW-1:0]         qry_start;
	logic [PW-1:0]         low_bit;
	logic [PW-1:0]         nxt_up;
	logic [PW-1:0]         nxt_dn;
	logic                  accept;
	logic                  upd_go;
	logic                  upd_more;
	logic                  qry_go;
	logic                  qry_more;
	logic                  out_free;
	sum_t                  acc_next;

	// The effective size saturates the register at SIZE, the highest memory address.
	always_comb begin
		size_c    = CW'(size_q);
		eff_c     = (size_c > CW'(SIZE)) ? CW'(SIZE) : size_c;
		idx_c     = CW'(index);
		qpos_c    = (idx_c > eff_c) ? eff_c : idx_c;
		eff       = PW'(eff_c);
		upd_start = PW'(idx_c);
		qry_start = PW'(qpos_c);
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;

	// An add walks only when its index lies inside 1..size; otherwise it is dropped.
	assign upd_go = accept && (operation == OP_ADD) && (idx_c != '0) && (idx_c <= eff_c);
	assign qry_go = accept && (operation == OP_QUERY) && (qpos_c != '0);

	// Upward step adds the lowest set bit, downward step clears it.
	assign low_bit  = pos_q & (~pos_q + PW'(1));
	assign nxt_up   = pos_q + low_bit;
	assign nxt_dn   = pos_q & (pos_q - PW'(1));
	assign upd_more = (nxt_up <= lim_q);
	assign qry_more = (nxt_dn != '0);
	assign acc_next = acc_q + mem_rdata;
	assign out_free = !out_valid_q || out_ready;

	// The write of one walk step and the read of the next hit different
	// entries, and the next request reads only after the last write landed.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q[AW-1:0];
		mem_wdata = mem_rdata + delta_q;
		mem_re    = 1'b0;
		mem_raddr = pos_q[AW-1:0];
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_IDLE: begin
				mem_re    = upd_go || qry_go;
				mem_raddr = upd_go ? upd_start[AW-1:0] : qry_start[AW-1:0];
			end
			ST_UPD: begin
				mem_we    = 1'b1;
				mem_re    = upd_more;
				mem_raddr = nxt_up[AW-1:0];
			end
			ST_QRY: begin
				mem_re    = qry_more;
				mem_raddr = nxt_dn[AW-1:0];
			end
			default: begin
				mem_we = 1'b0;
				mem_re = 1'b0;
			end
		endcase
	end

	fwt_ram #(
		.DEPTH (SIZE + 1),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Control state: sequencer, clearing counter, size register, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			size_q      <= SIZE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				size_q <= size_in_use;
			end
			// A new result may replace the one taken at this same edge.
			if ((state_q == ST_QOUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(SIZE)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (upd_go) begin
						state_q <= ST_UPD;
					end else if (qry_go) begin
						state_q <= ST_QRY;
					end else if (accept && (operation == OP_QUERY)) begin
						state_q <= ST_QOUT;
					end
				end
				ST_UPD: begin
					if (!upd_more) begin
						state_q <= ST_IDLE;
					end
				end
				ST_QRY: begin
					if (!qry_more) begin
						state_q <= ST_QOUT;
					end
				end
				ST_QOUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Walk position, limit, delta and running sum of the request at work.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				lim_q   <= eff;
				delta_q <= sum_t'(delta);
				acc_q   <= '0;
				pos_q   <= upd_go ? upd_start : qry_start;
			end
			ST_UPD: begin
				pos_q <= nxt_up;
			end
			ST_QRY: begin
				pos_q <= nxt_dn;
				acc_q <= acc_next;
			end
			ST_QOUT: begin
				if (out_free) begin
					prefix_sum_q <= acc_q;
				end
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign prefix_sum = signed'(prefix_sum_q);

`include "fenwick_tree_prefix_sum_core_assert.svh"

	// An update step always sits on a position inside the tree.
	`FWT_ASSERT(a_upd_pos, (state_q == ST_UPD) |-> (pos_q != '0 && pos_q <= lim_q))
	// A query step never reads the unused entry zero.
	`FWT_ASSERT(a_qry_pos, (state_q == ST_QRY) |-> (pos_q != '0))
	// A walk never reads the entry that it writes in the same cycle.
	`FWT_ASSERT(a_mem_hazard, (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
	// Every accepted query leaves idle so that it produces a result.
	`FWT_ASSERT_NEXT(a_qry_busy, accept && (operation == OP_QUERY), state_q != ST_IDLE)

endmodule

`default_nettype wire
